// ----- sv/spring_network_force_accumulator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the spring network force accumulator
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef SPRING_NETWORK_FORCE_ACCUMULATOR_ASSERT_SVH
`define SPRING_NETWORK_FORCE_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define SNFA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SNFA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/snfa_pkg.sv -----
// ----------------------------------------------------------------------------
// snfa_pkg
// Types and constants shared by the spring network force accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package snfa_pkg;

   // controller states
   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SQ, ST_SQRT, ST_MUL, ST_DIV, ST_FSAVE,
      ST_RD_A, ST_WR_A, ST_RD_B, ST_WR_B, ST_OUT_RD, ST_OUT_WR
   } state_type;

   // datapath commands
   typedef enum logic [3:0] {
      OP_NONE, OP_CLEAR, OP_LOAD, OP_SQ, OP_SQRT, OP_MUL, OP_DIV, OP_FSAVE,
      OP_RD_A, OP_WR_A, OP_RD_B, OP_WR_B, OP_OUT_RD, OP_OUT_WR
   } op_type;

   // datapath status back to the controller
   typedef struct packed {
      logic step_last;
      logic comp_last;
      logic sweep_last;
      logic end_of_set;
   } status_type;

   // one accumulator entry
   typedef struct packed {
      logic [47:0] fx;
      logic [47:0] fy;
      logic [47:0] fz;
      logic [15:0] cnt;
   } entry_type;

   localparam int STEP_W = 6;
   localparam logic [STEP_W-1:0] SQ_LAST   = 6'd3;
   localparam logic [STEP_W-1:0] SQRT_LAST = 6'd34;
   localparam logic [STEP_W-1:0] MUL_LAST  = 6'd5;
   localparam logic [STEP_W-1:0] DIV_LAST  = 6'd48;
   localparam logic [1:0]        COMP_LAST = 2'd2;

   localparam logic [47:0] FORCE_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] FORCE_MIN = 48'h8000_0000_0000;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // saturating signed 48-bit add
   function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
      logic [48:0] s;
      s = {a[47], a} + {b[47], b};
      if (s[48] != s[47]) begin
         sat_add48 = s[48] ? FORCE_MIN : FORCE_MAX;
      end else begin
         sat_add48 = s[47:0];
      end
   endfunction

endpackage

`default_nettype wire

// ----- sv/snfa_ram.sv -----
// ----------------------------------------------------------------------------
// snfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module snfa_ram #(
   parameter int WIDTH = 160,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- sv/snfa_datapath.sv -----
// ----------------------------------------------------------------------------
// snfa_datapath
// Difference vector, square root, force multiply/divide, accumulator store.
// ----------------------------------------------------------------------------
`default_nettype none

module snfa_datapath #(
   parameter int MAX_PARTICLES = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire snfa_pkg::op_type    op,
   output snfa_pkg::status_type     status,
   input  wire logic [5:0]          req_end_a,
   input  wire logic [5:0]          req_end_b,
   input  wire logic signed [31:0]  req_a_pos_x,
   input  wire logic signed [31:0]  req_a_pos_y,
   input  wire logic signed [31:0]  req_a_pos_z,
   input  wire logic signed [31:0]  req_b_pos_x,
   input  wire logic signed [31:0]  req_b_pos_y,
   input  wire logic signed [31:0]  req_b_pos_z,
   input  wire logic [31:0]         req_stiffness,
   input  wire logic [30:0]         req_rest_length,
   input  wire logic                req_end_of_set,
   output logic                     rsp_strobe,
   output logic [5:0]               rsp_particle,
   output logic signed [47:0]       rsp_force_x,
   output logic signed [47:0]       rsp_force_y,
   output logic signed [47:0]       rsp_force_z,
   output logic [15:0]              rsp_spring_count,
   output logic                     rsp_last_particle
);

   localparam int AW     = $clog2(MAX_PARTICLES);
   localparam int READ_N = (MAX_PARTICLES < 64) ? MAX_PARTICLES : 64;
   localparam int EW     = $bits(snfa_pkg::entry_type);

   // captured item
   logic [5:0]  idx_a_ff, idx_b_ff;
   logic        eos_ff;
   logic [31:0] k_ff;
   logic [30:0] d0_ff;
   logic [32:0] dmag_ff [3];
   logic        dneg_ff [3];

   // arithmetic state
   logic [snfa_pkg::STEP_W-1:0] step_ff;
   logic [1:0]  comp_ff;
   logic [64:0] pp_ff;
   logic [69:0] s_ff;
   logic [36:0] srem_ff;
   logic [34:0] root_ff;
   logic [63:0] m_ff;
   logic [98:0] acc_ff;
   logic [50:0] drem_ff;
   logic [47:0] q_ff;
   logic        sat_ff;
   logic        zero_ff;
   logic [47:0] force_ff [3];
   logic [AW-1:0] sweep_ff;

   // combinational
   logic [32:0] diff [3];
   logic [32:0] dsel;
   logic [35:0] e_full, e_negv;
   logic        e_neg;
   logic [34:0] e_mag;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [1:0]  sq_sel;
   logic [38:0] s_rsh, s_trial;
   logic [50:0] dp;
   logic [51:0] d_rsh;
   logic [47:0] f_mag, f_val;
   logic        step_last;
   logic        sweep_last;
   logic        a_ok, b_ok, in_read;
   logic        wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   snfa_pkg::entry_type wr_data, rd_data;
   logic [EW-1:0] rd_raw;

   // component differences, b minus a
   assign diff[0] = {req_b_pos_x[31], req_b_pos_x} - {req_a_pos_x[31], req_a_pos_x};
   assign diff[1] = {req_b_pos_y[31], req_b_pos_y} - {req_a_pos_y[31], req_a_pos_y};
   assign diff[2] = {req_b_pos_z[31], req_b_pos_z} - {req_a_pos_z[31], req_a_pos_z};

   // stretch E = D - D0
   assign e_full = {1'b0, root_ff} - {5'b0, d0_ff};
   assign e_negv = -e_full;
   assign e_neg  = e_full[35];
   assign e_mag  = e_neg ? e_negv[34:0] : e_full[34:0];

   assign dsel   = (comp_ff == 2'd3) ? 33'd0 : dmag_ff[comp_ff];
   assign sq_sel = step_ff[1:0];

   // shared 32x32 multiplier operand select
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      case (op)
         snfa_pkg::OP_SQ: begin
            if (sq_sel != 2'd3) begin
               mul_a = dmag_ff[sq_sel][31:0];
               mul_b = dmag_ff[sq_sel][31:0];
            end
         end
         snfa_pkg::OP_MUL: begin
            case (step_ff)
               6'd0: begin mul_a = k_ff;          mul_b = dsel[31:0]; end
               6'd1: begin mul_a = m_ff[31:0];    mul_b = e_mag[31:0]; end
               6'd2: begin mul_a = m_ff[63:32];   mul_b = e_mag[31:0]; end
               6'd3: begin mul_a = m_ff[31:0];    mul_b = {29'd0, e_mag[34:32]}; end
               6'd4: begin mul_a = m_ff[63:32];   mul_b = {29'd0, e_mag[34:32]}; end
               default: begin mul_a = 32'd0; mul_b = 32'd0; end
            endcase
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // square root and division steps
   assign s_rsh   = {srem_ff, s_ff[69:68]};
   assign s_trial = {2'b00, root_ff, 2'b01};
   assign dp      = {root_ff, 16'd0};
   assign d_rsh   = {drem_ff, acc_ff[47]};

   // saturated, signed force of the current component
   always_comb begin
      f_mag = (sat_ff || q_ff[47]) ? snfa_pkg::FORCE_MAX : q_ff;
      if (zero_ff) begin
         f_mag = 48'd0;
      end
      f_val = (e_neg ^ dneg_ff[comp_ff]) ? -f_mag : f_mag;
   end

   // end of the current stepped operation
   always_comb begin
      case (op)
         snfa_pkg::OP_SQ:   step_last = (step_ff == snfa_pkg::SQ_LAST);
         snfa_pkg::OP_SQRT: step_last = (step_ff == snfa_pkg::SQRT_LAST);
         snfa_pkg::OP_MUL:  step_last = (step_ff == snfa_pkg::MUL_LAST);
         snfa_pkg::OP_DIV:  step_last = (step_ff == snfa_pkg::DIV_LAST);
         default:           step_last = 1'b0;
      endcase
   end

   assign sweep_last = (sweep_ff == AW'(MAX_PARTICLES - 1));
   assign a_ok       = (32'(idx_a_ff) < MAX_PARTICLES);
   assign b_ok       = (32'(idx_b_ff) < MAX_PARTICLES);
   assign in_read    = (32'(sweep_ff) < READ_N);

   assign status.step_last  = step_last;
   assign status.comp_last  = (comp_ff == snfa_pkg::COMP_LAST);
   assign status.sweep_last = sweep_last;
   assign status.end_of_set = eos_ff;

   // item capture and arithmetic sequencing
   always_ff @(posedge clock) begin
      case (op)
         snfa_pkg::OP_LOAD: begin
            idx_a_ff <= req_end_a;
            idx_b_ff <= req_end_b;
            eos_ff   <= req_end_of_set;
            k_ff     <= req_stiffness;
            d0_ff    <= req_rest_length;
            for (int i = 0; i < 3; i++) begin
               dneg_ff[i] <= diff[i][32];
               dmag_ff[i] <= diff[i][32] ? -diff[i] : diff[i];
            end
            s_ff    <= 70'd0;
            srem_ff <= 37'd0;
            root_ff <= 35'd0;
         end
         snfa_pkg::OP_SQ: begin
            if (sq_sel != 2'd3) begin
               pp_ff <= {dmag_ff[sq_sel][32], mul_p};
            end
            if (step_ff != 6'd0) begin
               s_ff <= s_ff + 70'(pp_ff);
            end
         end
         snfa_pkg::OP_SQRT: begin
            s_ff <= {s_ff[67:0], 2'b00};
            if (s_rsh >= s_trial) begin
               srem_ff <= 37'(s_rsh - s_trial);
               root_ff <= {root_ff[33:0], 1'b1};
            end else begin
               srem_ff <= s_rsh[36:0];
               root_ff <= {root_ff[33:0], 1'b0};
            end
         end
         snfa_pkg::OP_MUL: begin
            case (step_ff)
               6'd0: m_ff <= dsel[32] ? {k_ff, 32'd0} : mul_p;
               6'd1: pp_ff <= {1'b0, mul_p};
               6'd2: begin
                  pp_ff  <= {1'b0, mul_p};
                  acc_ff <= 99'(pp_ff[63:0]);
               end
               6'd3, 6'd4: begin
                  pp_ff  <= {1'b0, mul_p};
                  acc_ff <= acc_ff + (99'(pp_ff[63:0]) << 32);
               end
               default: acc_ff <= acc_ff + (99'(pp_ff[63:0]) << 64);
            endcase
         end
         snfa_pkg::OP_DIV: begin
            if (step_ff == 6'd0) begin
               drem_ff <= acc_ff[98:48];
               sat_ff  <= (acc_ff[98:48] >= dp);
               zero_ff <= (root_ff == 35'd0) || (e_mag == 35'd0) || (dsel == 33'd0);
               q_ff    <= 48'd0;
            end else begin
               acc_ff[47:0] <= {acc_ff[46:0], 1'b0};
               if (d_rsh >= {1'b0, dp}) begin
                  drem_ff <= 51'(d_rsh - {1'b0, dp});
                  q_ff    <= {q_ff[46:0], 1'b1};
               end else begin
                  drem_ff <= d_rsh[50:0];
                  q_ff    <= {q_ff[46:0], 1'b0};
               end
            end
         end
         snfa_pkg::OP_FSAVE: begin
            if (comp_ff != 2'd3) begin
               force_ff[comp_ff] <= f_val;
            end
         end
         default: begin
         end
      endcase
   end

   // step, component and sweep counters
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         comp_ff  <= 2'd0;
         sweep_ff <= '0;
      end else begin
         if (op == snfa_pkg::OP_LOAD) begin
            step_ff <= '0;
            comp_ff <= 2'd0;
         end else if (op == snfa_pkg::OP_FSAVE) begin
            comp_ff <= (comp_ff == snfa_pkg::COMP_LAST) ? 2'd0 : comp_ff + 2'd1;
         end else if (op == snfa_pkg::OP_SQ || op == snfa_pkg::OP_SQRT ||
                      op == snfa_pkg::OP_MUL || op == snfa_pkg::OP_DIV) begin
            step_ff <= step_last ? '0 : step_ff + 1'b1;
         end
         if (op == snfa_pkg::OP_OUT_WR || op == snfa_pkg::OP_CLEAR) begin
            sweep_ff <= sweep_last ? '0 : sweep_ff + 1'b1;
         end
      end
   end

   // accumulator read-modify-write and sweep clearing
   assign rd_data = snfa_pkg::entry_type'(rd_raw);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = sweep_ff;
      wr_data = '0;
      case (op)
         snfa_pkg::OP_RD_A: rd_addr = AW'(idx_a_ff);
         snfa_pkg::OP_RD_B: rd_addr = AW'(idx_b_ff);
         default:           rd_addr = sweep_ff;
      endcase
      case (op)
         snfa_pkg::OP_WR_A: begin
            wr_en      = a_ok;
            wr_addr    = AW'(idx_a_ff);
            wr_data.fx = snfa_pkg::sat_add48(rd_data.fx, force_ff[0]);
            wr_data.fy = snfa_pkg::sat_add48(rd_data.fy, force_ff[1]);
            wr_data.fz = snfa_pkg::sat_add48(rd_data.fz, force_ff[2]);
            wr_data.cnt = (rd_data.cnt == snfa_pkg::COUNT_MAX) ? rd_data.cnt
                                                                : rd_data.cnt + 16'd1;
         end
         snfa_pkg::OP_WR_B: begin
            wr_en      = b_ok;
            wr_addr    = AW'(idx_b_ff);
            wr_data.fx = snfa_pkg::sat_add48(rd_data.fx, -force_ff[0]);
            wr_data.fy = snfa_pkg::sat_add48(rd_data.fy, -force_ff[1]);
            wr_data.fz = snfa_pkg::sat_add48(rd_data.fz, -force_ff[2]);
            wr_data.cnt = (rd_data.cnt == snfa_pkg::COUNT_MAX) ? rd_data.cnt
                                                                : rd_data.cnt + 16'd1;
         end
         snfa_pkg::OP_OUT_WR, snfa_pkg::OP_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ff;
            wr_data = '0;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   snfa_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_PARTICLES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // readout result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= (op == snfa_pkg::OP_OUT_WR) && in_read;
      end
   end

   always_ff @(posedge clock) begin
      if (op == snfa_pkg::OP_OUT_WR) begin
         rsp_particle      <= 6'(sweep_ff);
         rsp_force_x       <= rd_data.fx;
         rsp_force_y       <= rd_data.fy;
         rsp_force_z       <= rd_data.fz;
         rsp_spring_count  <= rd_data.cnt;
         rsp_last_particle <= (32'(sweep_ff) == READ_N - 1);
      end
   end

endmodule

`default_nettype wire

// ----- sv/snfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// snfa_ctrl
// Sequencer: clearing pass, per-spring arithmetic, store update, readout.
// ----------------------------------------------------------------------------
`default_nettype none

module snfa_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire snfa_pkg::status_type status,
   output snfa_pkg::op_type          op
);

   snfa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= snfa_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         snfa_pkg::ST_CLEAR:  if (status.sweep_last) state_in = snfa_pkg::ST_IDLE;
         snfa_pkg::ST_IDLE:   if (start) state_in = snfa_pkg::ST_SQ;
         snfa_pkg::ST_SQ:     if (status.step_last) state_in = snfa_pkg::ST_SQRT;
         snfa_pkg::ST_SQRT:   if (status.step_last) state_in = snfa_pkg::ST_MUL;
         snfa_pkg::ST_MUL:    if (status.step_last) state_in = snfa_pkg::ST_DIV;
         snfa_pkg::ST_DIV:    if (status.step_last) state_in = snfa_pkg::ST_FSAVE;
         snfa_pkg::ST_FSAVE:  state_in = status.comp_last ? snfa_pkg::ST_RD_A
                                                          : snfa_pkg::ST_MUL;
         snfa_pkg::ST_RD_A:   state_in = snfa_pkg::ST_WR_A;
         snfa_pkg::ST_WR_A:   state_in = snfa_pkg::ST_RD_B;
         snfa_pkg::ST_RD_B:   state_in = snfa_pkg::ST_WR_B;
         snfa_pkg::ST_WR_B:   state_in = status.end_of_set ? snfa_pkg::ST_OUT_RD
                                                           : snfa_pkg::ST_IDLE;
         snfa_pkg::ST_OUT_RD: state_in = snfa_pkg::ST_OUT_WR;
         snfa_pkg::ST_OUT_WR: state_in = status.sweep_last ? snfa_pkg::ST_IDLE
                                                           : snfa_pkg::ST_OUT_RD;
         default:             state_in = snfa_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      busy = (state_ff != snfa_pkg::ST_IDLE);
      unique case (state_ff)
         snfa_pkg::ST_CLEAR:  op = snfa_pkg::OP_CLEAR;
         snfa_pkg::ST_IDLE:   op = start ? snfa_pkg::OP_LOAD : snfa_pkg::OP_NONE;
         snfa_pkg::ST_SQ:     op = snfa_pkg::OP_SQ;
         snfa_pkg::ST_SQRT:   op = snfa_pkg::OP_SQRT;
         snfa_pkg::ST_MUL:    op = snfa_pkg::OP_MUL;
         snfa_pkg::ST_DIV:    op = snfa_pkg::OP_DIV;
         snfa_pkg::ST_FSAVE:  op = snfa_pkg::OP_FSAVE;
         snfa_pkg::ST_RD_A:   op = snfa_pkg::OP_RD_A;
         snfa_pkg::ST_WR_A:   op = snfa_pkg::OP_WR_A;
         snfa_pkg::ST_RD_B:   op = snfa_pkg::OP_RD_B;
         snfa_pkg::ST_WR_B:   op = snfa_pkg::OP_WR_B;
         snfa_pkg::ST_OUT_RD: op = snfa_pkg::OP_OUT_RD;
         snfa_pkg::ST_OUT_WR: op = snfa_pkg::OP_OUT_WR;
         default:             op = snfa_pkg::OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/spring_network_force_accumulator.sv -----
// ----------------------------------------------------------------------------
// spring_network_force_accumulator
// Accumulates linear spring forces per particle and reads them out in bulk.
// ----------------------------------------------------------------------------
// Usage:
//   Present one spring on the req_ ports and raise start; the spring is taken
//   at a clock edge where start is high and busy is low. Its force
//   k*(D-D0)*dx/(65536*D) is added to end_a's accumulator and subtracted
//   from end_b's. Each spring keeps busy high for the squares, the
//   bit-serial square root, then per axis the 32x32 partial products, the
//   one-bit-per-cycle divider and the save of the axis force, and the two
//   store read/write pairs. Unless the spring ends a set, busy is low again
//   on the cycle after the last store write; no new spring is taken before
//   the last one is done. A spring with req_end_of_set high is applied, then
//   every entry of the store is read and cleared, one read and one write per
//   entry; the first min(MAX_PARTICLES, 64) entries appear as rsp_ results,
//   each held for one cycle with rsp_strobe high, the last one with
//   rsp_last_particle set. The receiver cannot stall; results are never held.
//   After reset the block clears its store, one entry per cycle, with busy
//   high.
// ----------------------------------------------------------------------------
`default_nettype none

module spring_network_force_accumulator #(
   parameter int MAX_PARTICLES = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [5:0]         req_end_a,
   input  wire logic [5:0]         req_end_b,
   input  wire logic signed [31:0] req_a_pos_x,
   input  wire logic signed [31:0] req_a_pos_y,
   input  wire logic signed [31:0] req_a_pos_z,
   input  wire logic signed [31:0] req_b_pos_x,
   input  wire logic signed [31:0] req_b_pos_y,
   input  wire logic signed [31:0] req_b_pos_z,
   input  wire logic [31:0]        req_stiffness,
   input  wire logic [30:0]        req_rest_length,
   input  wire logic               req_end_of_set,
   output logic                    rsp_strobe,
   output logic [5:0]              rsp_particle,
   output logic signed [47:0]      rsp_force_x,
   output logic signed [47:0]      rsp_force_y,
   output logic signed [47:0]      rsp_force_z,
   output logic [15:0]             rsp_spring_count,
   output logic                    rsp_last_particle
);

   snfa_pkg::op_type     op;
   snfa_pkg::status_type status;

   // sequencer
   snfa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .op     (op)
   );

   // arithmetic and store
   snfa_datapath #(
      .MAX_PARTICLES (MAX_PARTICLES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .status            (status),
      .req_end_a         (req_end_a),
      .req_end_b         (req_end_b),
      .req_a_pos_x       (req_a_pos_x),
      .req_a_pos_y       (req_a_pos_y),
      .req_a_pos_z       (req_a_pos_z),
      .req_b_pos_x       (req_b_pos_x),
      .req_b_pos_y       (req_b_pos_y),
      .req_b_pos_z       (req_b_pos_z),
      .req_stiffness     (req_stiffness),
      .req_rest_length   (req_rest_length),
      .req_end_of_set    (req_end_of_set),
      .rsp_strobe        (rsp_strobe),
      .rsp_particle      (rsp_particle),
      .rsp_force_x       (rsp_force_x),
      .rsp_force_y       (rsp_force_y),
      .rsp_force_z       (rsp_force_z),
      .rsp_spring_count  (rsp_spring_count),
      .rsp_last_particle (rsp_last_particle)
   );

endmodule

`default_nettype wire

// ----- sv/snfa_checker.sv -----
// ----------------------------------------------------------------------------
// snfa_checker
// Port-level checks on the accumulator's handshake and readout pattern.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spring_network_force_accumulator_assert.svh"

module snfa_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_strobe,
   input wire logic       rsp_last_particle
);

   // store clearing keeps the block busy right after reset
   `SNFA_ASSERT_NOW(a_clear_after_reset, $fell(reset), busy, "not busy after reset")

   // an accepted item keeps the block busy
   `SNFA_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "idle after accept")

   // readout results never come back to back while the run is open
   `SNFA_ASSERT_NOW(a_run_busy, rsp_strobe && !rsp_last_particle, busy, "run ended early")
   `SNFA_ASSERT_NEXT(a_strobe_gap, rsp_strobe, !rsp_strobe, "back-to-back results")

endmodule

bind spring_network_force_accumulator snfa_checker u_snfa_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_last_particle (rsp_last_particle)
);

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb: spring network force accumulator testbench
// Sends springs one item at a time, models the per-particle force and count
// stores alongside the block, and checks every readout result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   localparam int NPART = 64;
   localparam logic signed [47:0] F_HI = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] F_LO = 48'sh8000_0000_0000;
   localparam int CYCLE_LIMIT = 600000;

   // one expected readout item
   typedef struct {
      logic [5:0]         particle;
      logic signed [47:0] fx;
      logic signed [47:0] fy;
      logic signed [47:0] fz;
      logic [15:0]        count;
      logic               last;
   } particle_result;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [5:0] req_end_a = '0;
   logic [5:0] req_end_b = '0;
   logic signed [31:0] req_a_pos_x = '0, req_a_pos_y = '0, req_a_pos_z = '0;
   logic signed [31:0] req_b_pos_x = '0, req_b_pos_y = '0, req_b_pos_z = '0;
   logic [31:0] req_stiffness = '0;
   logic [30:0] req_rest_length = '0;
   logic req_end_of_set = 1'b0;
   logic rsp_strobe;
   logic [5:0] rsp_particle;
   logic signed [47:0] rsp_force_x, rsp_force_y, rsp_force_z;
   logic [15:0] rsp_spring_count;
   logic rsp_last_particle;

   // model stores and expected readout
   logic signed [47:0] force_x_acc[NPART];
   logic signed [47:0] force_y_acc[NPART];
   logic signed [47:0] force_z_acc[NPART];
   logic [15:0]        spring_cnt[NPART];
   particle_result     pending_readout[$];

   int errors = 0;
   int springs_sent = 0;
   int readouts = 0;
   int results_seen = 0;
   int cycles = 0;
   bit idle_on = 1'b1;

   spring_network_force_accumulator uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_end_a(req_end_a), .req_end_b(req_end_b),
      .req_a_pos_x(req_a_pos_x), .req_a_pos_y(req_a_pos_y), .req_a_pos_z(req_a_pos_z),
      .req_b_pos_x(req_b_pos_x), .req_b_pos_y(req_b_pos_y), .req_b_pos_z(req_b_pos_z),
      .req_stiffness(req_stiffness), .req_rest_length(req_rest_length),
      .req_end_of_set(req_end_of_set),
      .rsp_strobe(rsp_strobe), .rsp_particle(rsp_particle),
      .rsp_force_x(rsp_force_x), .rsp_force_y(rsp_force_y), .rsp_force_z(rsp_force_z),
      .rsp_spring_count(rsp_spring_count), .rsp_last_particle(rsp_last_particle)
   );

   always #4 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // saturating 48-bit signed sum
   function automatic logic signed [47:0] clamp_sum(input logic signed [47:0] a,
                                                    input logic signed [47:0] b);
      logic signed [48:0] s;
      s = 49'(a) + 49'(b);
      if (s > 49'(F_HI)) return F_HI;
      if (s < 49'(F_LO)) return F_LO;
      return s[47:0];
   endfunction

   // floor square root of the squared length, 35 result bits
   function automatic logic [35:0] spring_length(input logic [127:0] sq);
      logic [35:0] r;
      logic [35:0] c;
      r = '0;
      for (int b = 34; b >= 0; b--) begin
         c = r | (36'd1 << b);
         if ((128'(c) * 128'(c)) <= sq) r = c;
      end
      return r;
   endfunction

   // one axis of k*(D-D0)*d/(65536*D), truncated and saturated
   function automatic logic signed [47:0] axis_force(input logic [31:0] k,
                                                     input logic signed [37:0] e,
                                                     input logic signed [33:0] d,
                                                     input logic [35:0] len);
      logic [63:0]  m;
      logic [127:0] num;
      logic [127:0] q;
      logic [33:0]  dmag;
      logic [37:0]  emag;
      if (len == 0 || e == 0 || d == 0) return '0;
      dmag = d < 0 ? -d : d;
      emag = e < 0 ? -e : e;
      m = 64'({32'b0, k} * {30'b0, dmag});    // wraps at 64 bits
      num = 128'(m) * 128'(emag);
      q = num / (128'(len) << 16);
      if (q > 128'(F_HI)) q = 128'(F_HI);
      return ((e < 0) != (d < 0)) ? -q[47:0] : q[47:0];
   endfunction

   task automatic add_to_particle(input logic [5:0] idx, input logic signed [47:0] fx,
                                  input logic signed [47:0] fy,
                                  input logic signed [47:0] fz);
      force_x_acc[idx] = clamp_sum(force_x_acc[idx], fx);
      force_y_acc[idx] = clamp_sum(force_y_acc[idx], fy);
      force_z_acc[idx] = clamp_sum(force_z_acc[idx], fz);
      if (spring_cnt[idx] != 16'hFFFF) spring_cnt[idx] = spring_cnt[idx] + 1;
   endtask

   task automatic clear_stores();
      for (int i = 0; i < NPART; i++) begin
         force_x_acc[i] = '0;
         force_y_acc[i] = '0;
         force_z_acc[i] = '0;
         spring_cnt[i] = '0;
      end
   endtask

   // apply one accepted spring to the model, queue readout on end of set
   task automatic predict_spring();
      logic signed [33:0] dx, dy, dz;
      logic [33:0]        mx, my, mz;
      logic [127:0]       sq;
      logic [35:0]        len;
      logic signed [37:0] e;
      logic signed [47:0] fx, fy, fz;
      particle_result     r;
      dx = 34'(req_b_pos_x) - 34'(req_a_pos_x);
      dy = 34'(req_b_pos_y) - 34'(req_a_pos_y);
      dz = 34'(req_b_pos_z) - 34'(req_a_pos_z);
      mx = dx < 0 ? -dx : dx;
      my = dy < 0 ? -dy : dy;
      mz = dz < 0 ? -dz : dz;
      sq = 128'(mx) * 128'(mx) + 128'(my) * 128'(my) + 128'(mz) * 128'(mz);
      len = spring_length(sq);
      e = 38'(len) - 38'(req_rest_length);
      fx = axis_force(req_stiffness, e, dx, len);
      fy = axis_force(req_stiffness, e, dy, len);
      fz = axis_force(req_stiffness, e, dz, len);
      add_to_particle(req_end_a, fx, fy, fz);
      add_to_particle(req_end_b, -fx, -fy, -fz);
      if (req_end_of_set) begin
         for (int i = 0; i < NPART; i++) begin
            r.particle = 6'(i);
            r.fx = force_x_acc[i];
            r.fy = force_y_acc[i];
            r.fz = force_z_acc[i];
            r.count = spring_cnt[i];
            r.last = (i == NPART - 1);
            pending_readout.push_back(r);
         end
         clear_stores();
         readouts++;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [47:0] got,
                                  input logic [47:0] want);
      $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want, cycles);
      errors++;
   endtask

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      particle_result w;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (pending_readout.size() == 0) begin
            report_mismatch("unexpected result", 48'(rsp_particle), '0);
         end else begin
            w = pending_readout.pop_front();
            if (rsp_particle !== w.particle)
               report_mismatch("particle", 48'(rsp_particle), 48'(w.particle));
            if (rsp_force_x !== w.fx) report_mismatch("force_x", rsp_force_x, w.fx);
            if (rsp_force_y !== w.fy) report_mismatch("force_y", rsp_force_y, w.fy);
            if (rsp_force_z !== w.fz) report_mismatch("force_z", rsp_force_z, w.fz);
            if (rsp_spring_count !== w.count)
               report_mismatch("spring_count", 48'(rsp_spring_count), 48'(w.count));
            if (rsp_last_particle !== w.last)
               report_mismatch("last_particle", 48'(rsp_last_particle), 48'(w.last));
         end
      end
   end

   // send one spring, wait for acceptance, then predict it
   task automatic send_spring(input logic [5:0] a, input logic [5:0] b,
                              input logic [31:0] ax, input logic [31:0] ay,
                              input logic [31:0] az, input logic [31:0] bx,
                              input logic [31:0] by, input logic [31:0] bz,
                              input logic [31:0] k, input logic [30:0] d0,
                              input logic eos);
      @(posedge clock);
      start <= 1'b1;
      req_end_a <= a;
      req_end_b <= b;
      req_a_pos_x <= ax;
      req_a_pos_y <= ay;
      req_a_pos_z <= az;
      req_b_pos_x <= bx;
      req_b_pos_y <= by;
      req_b_pos_z <= bz;
      req_stiffness <= k;
      req_rest_length <= d0;
      req_end_of_set <= eos;
      do @(posedge clock); while (busy);
      predict_spring();
      start <= 1'b0;
      springs_sent++;
      if (idle_on && $urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 13)) @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_readout.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 32'h40_0000)) - 32'sh20_0000);
         default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      endcase
   endfunction

   // random spring; indices mostly clustered so entries collect several
   task automatic send_random_spring(input logic eos);
      logic [5:0] a, b;
      logic [31:0] ax, ay, az, bx, by, bz, k;
      logic [30:0] d0;
      bit flat;
      a = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
      b = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
      flat = ($urandom_range(0, 3) == 0);
      ax = rand_coord(); ay = rand_coord(); az = flat ? '0 : rand_coord();
      bx = rand_coord(); by = rand_coord(); bz = flat ? '0 : rand_coord();
      if ($urandom_range(0, 9) == 0) begin
         bx = ax; by = ay; bz = az;
      end
      k = ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 32'h0010_0000));
      d0 = ($urandom_range(0, 2) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h0400_0000));
      send_spring(a, b, ax, ay, az, bx, by, bz, k, d0, eos);
   endtask

   // field extremes, coincident ends, same particle twice, readout of a cleared store
   task automatic test_directed_cases();
      send_spring(6'd0, 6'd63, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF, 31'h0, 1'b0);
      send_spring(6'd63, 6'd0, 32'h7FFF_FFFF, 32'h0, 32'h0,
                  32'h8000_0000, 32'h0, 32'h0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0);
      send_spring(6'd5, 6'd6, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                  32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                  32'h0001_0000, 31'h0001_0000, 1'b0);
      send_spring(6'd7, 6'd7, 32'h0, 32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000,
                  32'h0, 32'h0002_0000, 32'h0001_0000, 1'b0);
      send_spring(6'd1, 6'd2, 32'h0, 32'h0, 32'h0, 32'h0005_0000, 32'h0, 32'h0,
                  32'h0001_0000, 31'h0005_0000, 1'b0);
      send_spring(6'd3, 6'd4, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0001_0000,
                  32'h0, 32'h0000_8000, 31'h0, 1'b0);
      send_spring(6'd8, 6'd9, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0,
                  32'h1234_5679, 32'hFFFF_FFFF, 32'h0, 32'h0, 31'h0, 1'b1);
      wait_drained();
      // readout of a cleared store after one zero-force spring on particle 10
      send_spring(6'd10, 6'd10, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                  32'h0, 31'h0, 1'b1);
      wait_drained();
   endtask

   // push one pair into both saturation rails
   task automatic test_force_saturation();
      for (int i = 0; i < 8; i++)
         send_spring(6'd20, 6'd21, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                     32'hFFFF_FFFF, 31'h0, i == 7);
      wait_drained();
   endtask

   // random sets ending in a readout
   task automatic test_random_sets(input int n_items);
      int sent;
      int len;
      sent = 0;
      while (sent < n_items) begin
         len = $urandom_range(1, 12);
         for (int i = 0; i < len; i++) send_random_spring(i == len - 1);
         sent += len;
         if ($urandom_range(0, 4) == 0) wait_drained();
      end
   endtask

   initial begin
      clear_stores();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_force_saturation();
      test_random_sets(220);
      idle_on = 1'b0;
      test_random_sets(40);
      wait_drained();
      repeat (300) @(posedge clock);
      $display("covered %0d springs, %0d readouts, %0d particle results checked",
               springs_sent, readouts, results_seen);
      $display("directed extremes, coincident and shared ends, saturation, random sets");
      if (errors == 0 && pending_readout.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d results outstanding", errors, pending_readout.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
